### src/bellman_ford_shortest_paths_top_macros.svh
// assertion helpers shared by the top level
`ifndef BELLMAN_FORD_SHORTEST_PATHS_TOP_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BFSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/bfsp_pkg.sv
package bfsp_pkg;

  localparam int NODE_BITS      = 6;
  localparam int COUNT_BITS     = 7;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int DIST_BITS      = 23;

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

  // configuration register indexes
  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_NODE = 1'b1;

  typedef struct packed {
    logic store_edge;
    logic init;
    logic issue;
    logic issue_check;
    logic emit;
    logic load_out;
    logic out_last;
    logic finish;
  } bfsp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic cycle_found;
  } bfsp_status_t;

endpackage

### src/bfsp_ram.sv
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/bfsp_ctrl.sv
module bfsp_ctrl import bfsp_pkg::*; #(
  parameter int MAX_EDGES = 128
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_valid,
  input  logic                                               in_last_edge,
  output logic                                               in_ready,
  input  logic                                               out_ready,
  output logic                                               out_valid,
  input  logic [COUNT_BITS-1:0]                              n_eff,
  input  logic [$clog2(MAX_EDGES+1)-1:0]                     edge_total,
  input  bfsp_status_t                                       status,
  output bfsp_cmd_t                                          cmd,
  output logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_addr,
  output logic [NODE_BITS-1:0]                               emit_idx
);

  localparam int EDGE_AW    = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int TOTAL_BITS = $clog2(MAX_EDGES + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_RUN     = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [EDGE_AW-1:0]   idx_r, idx_nxt;
  logic [NODE_BITS-1:0] pass_r, pass_nxt;
  logic [NODE_BITS-1:0] emit_r, emit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 last_pass, last_idx, last_node, slot_free;

  // the final pass over the edges only looks for a negative cycle
  assign last_pass = {1'b0, pass_r} == n_eff - COUNT_BITS'(1);
  assign last_idx  = TOTAL_BITS'(idx_r) == edge_total - TOTAL_BITS'(1);
  assign last_node = {1'b0, emit_r} == n_eff - COUNT_BITS'(1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_edge = 1'b1;
          if (in_last_edge) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        idx_nxt   = '0;
        pass_nxt  = '0;
        state_nxt = (edge_total == '0) ? S_DRAIN : S_RUN;
      end
      S_RUN: begin
        cmd.issue       = 1'b1;
        cmd.issue_check = last_pass;
        if (last_idx) begin
          idx_nxt = '0;
          if (last_pass) begin
            state_nxt = S_DRAIN;
          end else begin
            pass_nxt = pass_r + NODE_BITS'(1);
          end
        end else begin
          idx_nxt = idx_r + EDGE_AW'(1);
        end
      end
      S_DRAIN: begin
        emit_nxt = '0;
        if (!status.pipe_busy) begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.emit  = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit = 1'b1;
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_last  = status.cycle_found || last_node;
          out_valid_nxt = 1'b1;
          if (cmd.out_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            emit_nxt  = emit_r + NODE_BITS'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pass_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign edge_addr = idx_r;
  assign emit_idx  = emit_r;

endmodule

### src/bfsp_dpath.sv
module bfsp_dpath import bfsp_pkg::*; #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 128,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic [NODE_BITS-1:0]                               in_edge_source,
  input  logic [NODE_BITS-1:0]                               in_edge_dest,
  input  logic signed [IN_WEIGHT_BITS-1:0]                   in_edge_weight,
  input  logic [COUNT_BITS-1:0]                              n_eff,
  input  logic [NODE_BITS-1:0]                               source_node,
  input  bfsp_cmd_t                                          cmd,
  input  logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_addr,
  input  logic [NODE_BITS-1:0]                               emit_idx,
  output logic [$clog2(MAX_EDGES+1)-1:0]                     edge_total,
  output bfsp_status_t                                       status,
  output logic [NODE_BITS-1:0]                               out_node_index,
  output logic signed [DIST_BITS-1:0]                        out_path_cost,
  output logic                                               out_reachable,
  output logic                                               out_negative_cycle,
  output logic                                               out_edges_dropped,
  output logic                                               out_last_result
);

  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int EDGE_AW    = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int TOTAL_BITS = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W     = 2 * NODE_BITS + WEIGHT_BITS;
  localparam int SUM_BITS   = (WEIGHT_BITS > DIST_BITS ? WEIGHT_BITS : DIST_BITS) + 1;

  // edge loading
  logic [TOTAL_BITS-1:0]         edge_total_r;
  logic                          drop_r;
  logic                          edge_ok, edge_we;
  logic signed [WEIGHT_BITS-1:0] w_store;
  logic [EDGE_W-1:0]             edge_wdata, edge_rdata;

  generate
    if (WEIGHT_BITS <= IN_WEIGHT_BITS) begin : g_w_trunc
      assign w_store = in_edge_weight[WEIGHT_BITS-1:0];
    end else begin : g_w_ext
      assign w_store = {{(WEIGHT_BITS-IN_WEIGHT_BITS){in_edge_weight[IN_WEIGHT_BITS-1]}},
                        in_edge_weight};
    end
  endgenerate

  assign edge_ok    = ({1'b0, in_edge_source} < n_eff) && ({1'b0, in_edge_dest} < n_eff) &&
                      (edge_total_r < TOTAL_BITS'(MAX_EDGES));
  assign edge_we    = cmd.store_edge && edge_ok;
  assign edge_wdata = {in_edge_source, in_edge_dest, w_store};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      drop_r       <= 1'b0;
    end else if (cmd.finish) begin
      edge_total_r <= '0;
      drop_r       <= 1'b0;
    end else if (cmd.store_edge) begin
      if (edge_ok) begin
        edge_total_r <= edge_total_r + TOTAL_BITS'(1);
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  bfsp_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total_r[EDGE_AW-1:0]),
    .wdata (edge_wdata),
    .raddr (edge_addr),
    .rdata (edge_rdata)
  );

  // stage 1: edge word is out of the store, distances are fetched
  logic                 s1_valid_r, s1_check_r;
  logic [NODE_BITS-1:0] e_u, e_v;
  logic                 e_in_range;

  assign e_u        = edge_rdata[EDGE_W-1 -: NODE_BITS];
  assign e_v        = edge_rdata[EDGE_W-NODE_BITS-1 -: NODE_BITS];
  assign e_in_range = ({1'b0, e_u} < n_eff) && ({1'b0, e_v} < n_eff);

  // stage 2: relax or test one edge
  logic                          s2_valid_r, s2_check_r, s2_range_r;
  logic [NODE_AW-1:0]            s2_u_r, s2_v_r;
  logic signed [WEIGHT_BITS-1:0] s2_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_check_r <= cmd.issue_check;
    s2_check_r <= s1_check_r;
    s2_range_r <= e_in_range;
    s2_u_r     <= e_u[NODE_AW-1:0];
    s2_v_r     <= e_v[NODE_AW-1:0];
    s2_w_r     <= edge_rdata[WEIGHT_BITS-1:0];
  end

  // distance store, two copies for two reads a cycle
  logic [NODE_AW-1:0]          rd_a_addr, dist_waddr;
  logic [DIST_BITS-1:0]        dist_a_rdata, dist_b_rdata;
  logic                        dist_we, init_we, relax_we, src_ok;
  logic signed [DIST_BITS-1:0] dist_wdata, sat_cand;

  assign rd_a_addr = cmd.emit ? emit_idx[NODE_AW-1:0] : e_u[NODE_AW-1:0];

  bfsp_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_NODES)
  ) u_dist_ram_a (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (rd_a_addr),
    .rdata (dist_a_rdata)
  );

  bfsp_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_NODES)
  ) u_dist_ram_b (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (e_v[NODE_AW-1:0]),
    .rdata (dist_b_rdata)
  );

  // the write of the previous cycle is not yet in the read data
  logic                        fwd_valid_r;
  logic [NODE_AW-1:0]          fwd_addr_r;
  logic signed [DIST_BITS-1:0] fwd_data_r;
  logic signed [DIST_BITS-1:0] du, dv;
  logic signed [SUM_BITS-1:0]  cand;
  logic [MAX_NODES-1:0]        reach_r, reach_nxt;
  logic                        u_reach, v_reach, take, upd;
  logic                        cycle_r;

  assign du = (fwd_valid_r && (fwd_addr_r == s2_u_r)) ? fwd_data_r : dist_a_rdata;
  assign dv = (fwd_valid_r && (fwd_addr_r == s2_v_r)) ? fwd_data_r : dist_b_rdata;

  assign u_reach = reach_r[s2_u_r];
  assign v_reach = reach_r[s2_v_r];
  assign take    = s2_valid_r && s2_range_r && u_reach;
  assign cand    = SUM_BITS'(du) + SUM_BITS'(s2_w_r);
  assign upd     = take && (!v_reach || (cand < SUM_BITS'(dv)));

  always_comb begin
    if (cand > SUM_BITS'(DIST_MAX)) begin
      sat_cand = DIST_MAX;
    end else if (cand < SUM_BITS'(DIST_MIN)) begin
      sat_cand = DIST_MIN;
    end else begin
      sat_cand = cand[DIST_BITS-1:0];
    end
  end

  assign src_ok     = {1'b0, source_node} < n_eff;
  assign init_we    = cmd.init && src_ok;
  assign relax_we   = upd && !s2_check_r;
  assign dist_we    = init_we || relax_we;
  assign dist_waddr = cmd.init ? source_node[NODE_AW-1:0] : s2_v_r;
  assign dist_wdata = cmd.init ? '0 : sat_cand;

  always_comb begin
    reach_nxt = reach_r;
    if (cmd.init) begin
      reach_nxt = '0;
      if (src_ok) begin
        reach_nxt[source_node[NODE_AW-1:0]] = 1'b1;
      end
    end else if (relax_we) begin
      reach_nxt[s2_v_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r     <= '0;
      cycle_r     <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      reach_r     <= reach_nxt;
      fwd_valid_r <= dist_we;
      if (cmd.init) begin
        cycle_r <= 1'b0;
      end else if (upd && s2_check_r) begin
        cycle_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= dist_waddr;
    fwd_data_r <= dist_wdata;
  end

  // result word
  logic                        emit_reach;
  logic [NODE_BITS-1:0]        node_index_r;
  logic signed [DIST_BITS-1:0] path_cost_r;
  logic                        reachable_r, negative_cycle_r, edges_dropped_r, last_result_r;

  assign emit_reach = reach_r[emit_idx[NODE_AW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      node_index_r     <= cycle_r ? '0 : emit_idx;
      path_cost_r      <= (!cycle_r && emit_reach) ? dist_a_rdata : '0;
      reachable_r      <= !cycle_r && emit_reach;
      negative_cycle_r <= cycle_r;
      edges_dropped_r  <= drop_r;
      last_result_r    <= cmd.out_last;
    end
  end

  assign edge_total         = edge_total_r;
  assign status.pipe_busy   = s1_valid_r || s2_valid_r;
  assign status.cycle_found = cycle_r;

  assign out_node_index     = node_index_r;
  assign out_path_cost      = path_cost_r;
  assign out_reachable      = reachable_r;
  assign out_negative_cycle = negative_cycle_r;
  assign out_edges_dropped  = edges_dropped_r;
  assign out_last_result    = last_result_r;

endmodule

### src/bellman_ford_shortest_paths_top.sv
// loading: one edge word per cycle; ready stays low from the last edge to the last result word
// run: a set-up state, then n passes over the edges (n-1 relaxation passes and one
// cycle-check pass, one edge per cycle through the edge memory read port), then a pipeline drain
// results: one distance memory read per result word, then a load once the output slot is free
// reset (rst_n, synchronous, active low) clears edge count, drop flag, reach bits and control,
// sets node_count to 1 and source_node to 0; edge and distance memories are not cleared
`include "bellman_ford_shortest_paths_top_macros.svh"

module bellman_ford_shortest_paths_top import bfsp_pkg::*; #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 128,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [COUNT_BITS-1:0]             cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [NODE_BITS-1:0]              in_edge_source,
  input  logic [NODE_BITS-1:0]              in_edge_dest,
  input  logic signed [IN_WEIGHT_BITS-1:0]  in_edge_weight,
  input  logic                              in_last_edge,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [NODE_BITS-1:0]              out_node_index,
  output logic signed [DIST_BITS-1:0]       out_path_cost,
  output logic                              out_reachable,
  output logic                              out_negative_cycle,
  output logic                              out_edges_dropped,
  output logic                              out_last_result
);

  localparam int EDGE_AW    = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int TOTAL_BITS = $clog2(MAX_EDGES + 1);

  logic [COUNT_BITS-1:0] node_count_r;
  logic [NODE_BITS-1:0]  source_node_r;
  logic [COUNT_BITS-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= COUNT_BITS'(1);
      source_node_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT:  node_count_r  <= cfg_wdata;
        CFG_SOURCE_NODE: source_node_r <= cfg_wdata[NODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // node count in use, clamped to one and to the node capacity
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = COUNT_BITS'(1);
    end else if (node_count_r > COUNT_BITS'(MAX_NODES)) begin
      n_eff = COUNT_BITS'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  bfsp_cmd_t             cmd;
  bfsp_status_t          status;
  logic [EDGE_AW-1:0]    edge_addr;
  logic [NODE_BITS-1:0]  emit_idx;
  logic [TOTAL_BITS-1:0] edge_total;

  bfsp_ctrl #(
    .MAX_EDGES (MAX_EDGES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_edge (in_last_edge),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .n_eff        (n_eff),
    .edge_total   (edge_total),
    .status       (status),
    .cmd          (cmd),
    .edge_addr    (edge_addr),
    .emit_idx     (emit_idx)
  );

  bfsp_dpath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_edge_source     (in_edge_source),
    .in_edge_dest       (in_edge_dest),
    .in_edge_weight     (in_edge_weight),
    .n_eff              (n_eff),
    .source_node        (source_node_r),
    .cmd                (cmd),
    .edge_addr          (edge_addr),
    .emit_idx           (emit_idx),
    .edge_total         (edge_total),
    .status             (status),
    .out_node_index     (out_node_index),
    .out_path_cost      (out_path_cost),
    .out_reachable      (out_reachable),
    .out_negative_cycle (out_negative_cycle),
    .out_edges_dropped  (out_edges_dropped),
    .out_last_result    (out_last_result)
  );

  `BFSP_ASSERT_NOW(a_cycle_word_alone, out_valid && out_negative_cycle, out_last_result && !out_reachable && (out_node_index == '0), "cycle report is not a lone final word")
  `BFSP_ASSERT_NOW(a_unreached_cost_zero, out_valid && !out_reachable, out_path_cost == '0, "unreachable node carries a cost")
  `BFSP_ASSERT_NEXT(a_last_edge_closes_input, in_valid && in_ready && in_last_edge, !in_ready, "input still open after last edge")
  `BFSP_ASSERT_NOW(a_no_relax_while_loading, cmd.issue, !in_ready, "edge pass running while input open")

endmodule

### sim/bellman_ford_shortest_paths_top_test.sv
`timescale 1ns / 100ps

module bellman_ford_shortest_paths_top_test;
  import bfsp_pkg::*;

  localparam int NODE_SLOTS  = 64;
  localparam int EDGE_SLOTS  = 128;
  localparam int RANDOM_EDGES = 405;
  localparam int CALM_EDGES  = 50;
  localparam int SETTLE      = 8;
  localparam int DRAIN       = 16;
  localparam int STALL_LIMIT = 30000;

  typedef struct packed {
    logic [NODE_BITS-1:0] node;
    logic [DIST_BITS-1:0] cost;
    logic                 reach;
    logic                 cyc;
    logic                 dropped;
    logic                 last;
  } path_result_t;

  typedef enum bit {ROW_CFG, ROW_EDGE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic                      cfg_idx;
    logic [COUNT_BITS-1:0]     cfg_val;
    logic [NODE_BITS-1:0]      src;
    logic [NODE_BITS-1:0]      dst;
    logic [IN_WEIGHT_BITS-1:0] wt;
    logic                      last;
    bit                        typed;
    path_result_t              want;
  } plan_row_t;

  typedef struct {
    logic [NODE_BITS-1:0] tail;
    logic [NODE_BITS-1:0] head;
    longint               cost;
  } edge_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_NODE_COUNT;
  logic [COUNT_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [NODE_BITS-1:0] in_edge_source = '0;
  logic [NODE_BITS-1:0] in_edge_dest = '0;
  logic signed [IN_WEIGHT_BITS-1:0] in_edge_weight = '0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NODE_BITS-1:0] out_node_index;
  logic signed [DIST_BITS-1:0] out_path_cost;
  logic out_reachable;
  logic out_negative_cycle;
  logic out_edges_dropped;
  logic out_last_result;

  bellman_ford_shortest_paths_top #(
    .MAX_NODES(NODE_SLOTS),
    .MAX_EDGES(EDGE_SLOTS),
    .WEIGHT_BITS(IN_WEIGHT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_edge_source(in_edge_source),
    .in_edge_dest(in_edge_dest),
    .in_edge_weight(in_edge_weight),
    .in_last_edge(in_last_edge),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_node_index(out_node_index),
    .out_path_cost(out_path_cost),
    .out_reachable(out_reachable),
    .out_negative_cycle(out_negative_cycle),
    .out_edges_dropped(out_edges_dropped),
    .out_last_result(out_last_result)
  );

  always #4 clk = ~clk;

  // shadow of the block's registers and edge list
  logic [COUNT_BITS-1:0] node_cnt_reg = 7'd1;
  logic [NODE_BITS-1:0]  src_reg = '0;
  logic                  drop_pending = 1'b0;
  edge_rec_t             route_edges[$];
  path_result_t          predicted[$];
  path_result_t          pending_paths[$];

  int fails = 0;
  int words_sent = 0;
  int edges_stored = 0;
  int searches = 0;
  int results_checked = 0;
  int cycle_reports = 0;
  int dropped_seen = 0;
  int quiet_cycles = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  int sink_gap = 0;

  function automatic int active_nodes();
    if (node_cnt_reg == 0) return 1;
    if (node_cnt_reg > NODE_SLOTS) return NODE_SLOTS;
    return int'(node_cnt_reg);
  endfunction

  // stores one edge word or marks it dropped; on the last word runs the search and fills predicted
  function automatic void load_edge_and_search(input logic [NODE_BITS-1:0] s,
                                               input logic [NODE_BITS-1:0] d,
                                               input logic [IN_WEIGHT_BITS-1:0] w,
                                               input logic last);
    int n;
    int u;
    int v;
    longint dist_est[NODE_SLOTS];
    longint cand;
    longint dist_hi;
    longint dist_lo;
    logic [NODE_SLOTS-1:0] reach;
    logic [DIST_BITS-1:0] cost_bits;
    bit cyc;
    edge_rec_t rec;
    n = active_nodes();
    dist_hi = DIST_MAX;
    dist_lo = DIST_MIN;
    predicted.delete();
    if (s >= n || d >= n || route_edges.size() >= EDGE_SLOTS) begin
      drop_pending = 1'b1;
    end else begin
      rec.tail = s;
      rec.head = d;
      rec.cost = longint'($signed(w));
      route_edges.push_back(rec);
      edges_stored++;
    end
    if (!last) return;
    searches++;
    for (int i = 0; i < NODE_SLOTS; i++) dist_est[i] = 0;
    reach = '0;
    if (src_reg < n) reach[src_reg] = 1'b1;
    for (int p = 0; p + 1 < n; p++) begin
      foreach (route_edges[j]) begin
        u = int'(route_edges[j].tail);
        v = int'(route_edges[j].head);
        // edges naming nodes beyond a reduced node count sit out the search
        if (u < n && v < n && reach[u]) begin
          cand = dist_est[u] + route_edges[j].cost;
          if (!reach[v] || cand < dist_est[v]) begin
            if (cand > dist_hi) dist_est[v] = dist_hi;
            else if (cand < dist_lo) dist_est[v] = dist_lo;
            else dist_est[v] = cand;
            reach[v] = 1'b1;
          end
        end
      end
    end
    cyc = 1'b0;
    foreach (route_edges[j]) begin
      u = int'(route_edges[j].tail);
      v = int'(route_edges[j].head);
      if (!cyc && u < n && v < n && reach[u] &&
          (!reach[v] || dist_est[u] + route_edges[j].cost < dist_est[v]))
        cyc = 1'b1;
    end
    if (cyc) begin
      predicted.push_back('{'0, '0, 1'b0, 1'b1, drop_pending, 1'b1});
    end else begin
      for (int j = 0; j < n; j++) begin
        cost_bits = dist_est[j][DIST_BITS-1:0];
        predicted.push_back('{NODE_BITS'(j), reach[j] ? cost_bits : '0, reach[j], 1'b0,
                              drop_pending, 1'(j + 1 == n)});
      end
    end
    route_edges.delete();
    drop_pending = 1'b0;
  endfunction

  function automatic plan_row_t edge_row(input int s, input int d, input int w, input bit last);
    plan_row_t r;
    r = '0;
    r.kind = ROW_EDGE;
    r.src = NODE_BITS'(s);
    r.dst = NODE_BITS'(d);
    r.wt = IN_WEIGHT_BITS'(w);
    r.last = last;
    return r;
  endfunction

  // single-node searches, where the one result word is plain to see
  function automatic plan_row_t typed_row(input int s, input int d, input int w,
                                          input bit reach, input bit cyc, input bit dropped);
    plan_row_t r;
    r = edge_row(s, d, w, 1'b1);
    r.typed = 1'b1;
    r.want = '{'0, '0, reach, cyc, dropped, 1'b1};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic idx, input int val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = COUNT_BITS'(val);
    return r;
  endfunction

  function automatic void flag_field(input string field, input longint want, input longint got);
    fails++;
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
  endfunction

  // register writes only once the block has gone quiet
  task automatic write_reg(input logic idx, input logic [COUNT_BITS-1:0] val);
    @(negedge clk) in_valid <= 1'b0;
    while (pending_paths.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == CFG_NODE_COUNT) node_cnt_reg = val;
    else src_reg = val[NODE_BITS-1:0];
  endtask

  task automatic send_edge(input logic [NODE_BITS-1:0] s, input logic [NODE_BITS-1:0] d,
                           input logic [IN_WEIGHT_BITS-1:0] w, input logic last,
                           input bit typed, input path_result_t want);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_edge_source <= s;
    in_edge_dest <= d;
    in_edge_weight <= w;
    in_last_edge <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    load_edge_and_search(s, d, w, last);
    if (typed) pending_paths.push_back(want);
    else foreach (predicted[k]) pending_paths.push_back(predicted[k]);
  endtask

  always @(negedge clk) begin
    if (!sink_idle_on) begin
      out_ready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    path_result_t got;
    path_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_node_index, out_path_cost, out_reachable, out_negative_cycle,
              out_edges_dropped, out_last_result};
      if (pending_paths.size() == 0) begin
        fails++;
        $display("%0t: result word with none expected: node %0d cost %0d", $time,
                 got.node, $signed(got.cost));
      end else begin
        want = pending_paths.pop_front();
        results_checked++;
        if (want.cyc) cycle_reports++;
        if (want.dropped) dropped_seen++;
        if (got.node !== want.node) flag_field("node_index", want.node, got.node);
        if (got.cost !== want.cost)
          flag_field("path_cost", longint'($signed(want.cost)), longint'($signed(got.cost)));
        if (got.reach !== want.reach) flag_field("reachable", want.reach, got.reach);
        if (got.cyc !== want.cyc) flag_field("negative_cycle", want.cyc, got.cyc);
        if (got.dropped !== want.dropped)
          flag_field("edges_dropped", want.dropped, got.dropped);
        if (got.last !== want.last) flag_field("last_result", want.last, got.last);
      end
    end
  end

  // long searches hold both channels still, so the limit covers a full 64 x 128 run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("bellman_ford_shortest_paths_top verification failed");
      $finish;
    end
  end

  initial begin
    plan_row_t directed_plan[$];
    int n;
    int e;
    int style;
    int pick;
    int nc;
    int random_base;
    int random_sent;
    int cap_runs;
    int wide_runs;
    bit first;
    logic [NODE_BITS-1:0] s;
    logic [NODE_BITS-1:0] d;
    logic [IN_WEIGHT_BITS-1:0] w;

    directed_plan = '{
      typed_row(0, 0, 32767, 1'b1, 1'b0, 1'b0),
      typed_row(0, 0, -32768, 1'b0, 1'b1, 1'b0),
      typed_row(63, 63, 0, 1'b1, 1'b0, 1'b1),
      cfg_row(CFG_NODE_COUNT, 0),
      typed_row(0, 0, -1, 1'b0, 1'b1, 1'b0),
      typed_row(0, 1, 5, 1'b1, 1'b0, 1'b1),
      cfg_row(CFG_NODE_COUNT, 4),
      cfg_row(CFG_SOURCE_NODE, 0),
      edge_row(0, 1, 5, 1'b0),
      edge_row(1, 2, -3, 1'b0),
      edge_row(0, 2, 10, 1'b0),
      edge_row(2, 3, 32767, 1'b1),
      cfg_row(CFG_NODE_COUNT, 127),
      cfg_row(CFG_SOURCE_NODE, 63),
      edge_row(63, 0, -32768, 1'b0),
      edge_row(0, 1, -32768, 1'b0),
      edge_row(1, 62, -32768, 1'b1),
      cfg_row(CFG_NODE_COUNT, 8),
      cfg_row(CFG_SOURCE_NODE, 0),
      edge_row(0, 7, 1, 1'b0),
      edge_row(7, 6, 2, 1'b0),
      // shrink the graph under edges already stored
      cfg_row(CFG_NODE_COUNT, 4),
      edge_row(0, 3, -5, 1'b1),
      cfg_row(CFG_NODE_COUNT, 3),
      cfg_row(CFG_SOURCE_NODE, 5),
      edge_row(0, 1, 1, 1'b1),
      cfg_row(CFG_NODE_COUNT, 64),
      cfg_row(CFG_SOURCE_NODE, 0),
      // stacked self loops drive the distance into saturation
      edge_row(0, 0, -32768, 1'b0),
      edge_row(0, 0, -32768, 1'b0),
      edge_row(0, 0, -32768, 1'b0),
      edge_row(0, 0, -32768, 1'b1),
      cfg_row(CFG_NODE_COUNT, 4),
      // negative loop that the source cannot reach
      edge_row(2, 3, -100, 1'b0),
      edge_row(3, 2, -100, 1'b0),
      edge_row(0, 1, 7, 1'b1)
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG)
        write_reg(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
      else
        send_edge(directed_plan[i].src, directed_plan[i].dst, directed_plan[i].wt,
                  directed_plan[i].last, directed_plan[i].typed, directed_plan[i].want);
    end

    random_base = words_sent;
    random_sent = 0;
    cap_runs = 0;
    wide_runs = 0;
    first = 1'b1;
    while (random_sent < RANDOM_EDGES) begin
      if (random_sent >= RANDOM_EDGES - CALM_EDGES) begin
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (first || $urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 19);
        if (first) nc = 2;
        else if (wide_runs == 0 && random_sent > 150) nc = 64;
        else if (pick < 13) nc = $urandom_range(2, 12);
        else if (pick < 15) nc = $urandom_range(13, 64);
        else if (pick == 15) nc = 0;
        else if (pick == 16) nc = $urandom_range(65, 127);
        else nc = 1;
        write_reg(CFG_NODE_COUNT, COUNT_BITS'(nc));
        n = active_nodes();
        if ($urandom_range(0, 7) == 0) write_reg(CFG_SOURCE_NODE, 7'($urandom_range(0, 63)));
        else write_reg(CFG_SOURCE_NODE, 7'($urandom_range(0, n - 1)));
        first = 1'b0;
      end
      n = active_nodes();
      if (n <= 4 && (cap_runs == 0 || (cap_runs < 3 && $urandom_range(0, 9) == 0))) begin
        // overfill the edge memory
        e = $urandom_range(EDGE_SLOTS + 1, EDGE_SLOTS + 8);
        cap_runs++;
      end else if (n >= 32 && wide_runs < 2) begin
        e = $urandom_range(100, EDGE_SLOTS);
        wide_runs++;
      end else begin
        e = $urandom_range(1, 16);
      end
      if (e > RANDOM_EDGES - random_sent) e = RANDOM_EDGES - random_sent;
      style = $urandom_range(0, 3);
      for (int k = 0; k < e; k++) begin
        if (style == 3 || $urandom_range(0, 11) == 0) begin
          s = 6'($urandom_range(0, 63));
          d = 6'($urandom_range(0, 63));
        end else if (style == 1 && n >= 2) begin
          // forward edges, though the occasional random pick above can still close a loop
          s = 6'($urandom_range(0, n - 2));
          d = 6'($urandom_range(int'(s) + 1, n - 1));
        end else begin
          s = 6'($urandom_range(0, n - 1));
          d = 6'($urandom_range(0, n - 1));
        end
        if (style == 0) w = 16'($urandom_range(0, 2000));
        else if (style == 1 && $urandom_range(0, 7) != 0) w = 16'($urandom_range(0, 4000) - 2000);
        else if ($urandom_range(0, 4) == 0) w = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        else w = 16'($urandom());
        send_edge(s, d, w, 1'(k == e - 1), 1'b0, '0);
      end
      random_sent = words_sent - random_base;
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d edge words (%0d stored) over %0d searches, node counts 0 to 127",
             words_sent, edges_stored, searches);
    $display("checked %0d result words: %0d negative cycle reports, %0d with dropped edges",
             results_checked, cycle_reports, dropped_seen);
    if (fails == 0) begin
      $display("bellman_ford_shortest_paths_top verification clean");
    end else begin
      $display("bellman_ford_shortest_paths_top verification failed");
    end
    $finish;
  end

endmodule
